// File: src/pis_pkg.sv
// Shared types, constants and fixed-point helpers for the particle integration step.
`timescale 1ns / 1ps

package pis_pkg;

  localparam int FRAC_BITS = 16;

  localparam int VAL_W = 32;
  localparam int DT_W = 17;
  localparam int KIND_W = 3;
  localparam int PROD_W = 2 * VAL_W;
  localparam int DATA_IN_W = ((8 * VAL_W + DT_W + 7) / 8) * 8;
  localparam int DATA_OUT_W = 8 * VAL_W;

  localparam logic [KIND_W-1:0] KIND_BURST = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RAIN = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SMOKE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SPARK = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DUST = 3'd4;

  localparam longint ONE_L = longint'(1) << FRAC_BITS;

  localparam logic [VAL_W-1:0] FX_ONE = VAL_W'(ONE_L);
  localparam logic [VAL_W-1:0] K_SMOKE_RISE = VAL_W'((3 * ONE_L + 2) / 5);
  localparam logic [VAL_W-1:0] K_SMOKE_DRAG = VAL_W'((11 * ONE_L + 10) / 20);
  localparam logic [VAL_W-1:0] K_DUST_FALL = VAL_W'((9 * ONE_L + 1) / 2);
  localparam logic [VAL_W-1:0] K_DUST_DRAG = VAL_W'((6 * ONE_L + 2) / 5);
  localparam logic [VAL_W-1:0] K_SPARK_FALL = VAL_W'(14 * ONE_L);
  localparam logic [VAL_W-1:0] K_BURST_FALL = VAL_W'((19 * ONE_L + 1) / 2);
  localparam logic [VAL_W-1:0] K_DUST_FLOOR = VAL_W'((ONE_L + 12) / 25);

  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(longint'(1) << (FRAC_BITS - 1));
  localparam logic signed [PROD_W-1:0] S32_MAX_W = PROD_W'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [PROD_W-1:0] S32_MIN_W = PROD_W'(64'shFFFF_FFFF_8000_0000);
  localparam logic signed [VAL_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic signed [VAL_W-1:0] life;
    logic signed [VAL_W-1:0] px;
    logic signed [VAL_W-1:0] py;
    logic signed [VAL_W-1:0] pz;
    logic signed [VAL_W-1:0] vx;
    logic signed [VAL_W-1:0] vy;
    logic signed [VAL_W-1:0] vz;
    logic signed [VAL_W-1:0] size;
    logic [DT_W-1:0] dt;
  } particle_t;

  // Rounds a full product to nearest (ties up) and saturates it to 32 bits.
  function automatic logic signed [VAL_W-1:0] rnd_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] q;
    q = (p + ROUND_HALF) >>> FRAC_BITS;
    if (q > S32_MAX_W) begin
      rnd_sat = S32_MAX;
    end else if (q < S32_MIN_W) begin
      rnd_sat = S32_MIN;
    end else begin
      rnd_sat = q[VAL_W-1:0];
    end
  endfunction

  function automatic logic signed [VAL_W-1:0] add_sat(input logic signed [VAL_W-1:0] a,
                                                      input logic signed [VAL_W-1:0] b);
    logic signed [VAL_W:0] s;
    s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    if (s[VAL_W] != s[VAL_W-1]) begin
      add_sat = s[VAL_W] ? S32_MIN : S32_MAX;
    end else begin
      add_sat = s[VAL_W-1:0];
    end
  endfunction

  function automatic logic signed [VAL_W-1:0] sub_sat(input logic signed [VAL_W-1:0] a,
                                                      input logic signed [VAL_W-1:0] b);
    logic signed [VAL_W:0] s;
    s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
    if (s[VAL_W] != s[VAL_W-1]) begin
      sub_sat = s[VAL_W] ? S32_MIN : S32_MAX;
    end else begin
      sub_sat = s[VAL_W-1:0];
    end
  endfunction

  // Vertical acceleration constant of each kind; unknown codes behave as bursts.
  function automatic logic [VAL_W-1:0] rise_const(input logic [KIND_W-1:0] kind);
    case (kind)
      KIND_RAIN:  rise_const = '0;
      KIND_SMOKE: rise_const = K_SMOKE_RISE;
      KIND_SPARK: rise_const = K_SPARK_FALL;
      KIND_DUST:  rise_const = K_DUST_FALL;
      default:    rise_const = K_BURST_FALL;
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] drag_const(input logic [KIND_W-1:0] kind);
    case (kind)
      KIND_SMOKE: drag_const = K_SMOKE_DRAG;
      KIND_DUST:  drag_const = K_DUST_DRAG;
      default:    drag_const = '0;
    endcase
  endfunction

endpackage

// File: src/particle_integration_step.sv
// Eight-stage pipeline that advances one particle record by one time step per beat.
//
//   Channel  Dir  Beat contents
//   s_axis   in   tuser: particle_kind; tdata: life, position, velocity, size, time step
//   m_axis   out  tuser: out_kind; tdata: life, position, velocity, size
//
// One beat is accepted per cycle unless stalled; each beat passes through r1 to r8 in
// order. The depth is set by the chain of multiply, round and add steps, each in its
// own register stage. Particles whose life runs out leave a bubble and give no output
// beat. Reset clears only the stage valid bits. A stalled output holds every stage
// that is full, while empty stages keep filling, so no beat is lost or repeated.
`timescale 1ns / 1ps

module particle_integration_step (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // life_left, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, particle_size, time_step, zero fill
  input  logic [pis_pkg::DATA_IN_W-1:0]  s_axis_tdata,
  // particle_kind
  input  logic [pis_pkg::KIND_W-1:0]     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // out_life, out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y, out_vel_z, out_size
  output logic [pis_pkg::DATA_OUT_W-1:0] m_axis_tdata,
  // out_kind
  output logic [pis_pkg::KIND_W-1:0]     m_axis_tuser
);

  localparam int W = pis_pkg::VAL_W;
  localparam int PW = pis_pkg::PROD_W;
  localparam int DTS_W = pis_pkg::DT_W + 1;
  localparam int PV_W = W + DTS_W;

  logic [8:1] v;
  logic [8:1] en;

  pis_pkg::particle_t in_rec;
  pis_pkg::particle_t r1, r2, r3, r4, r5, r6, r7, r8;
  pis_pkg::particle_t r3_next, r5_next, r6_next, r8_next;

  logic signed [pis_pkg::PROD_W-1:0] pc1, pd1;
  logic signed [W-1:0] mc2, md2;
  logic signed [W-1:0] fac3;
  logic signed [pis_pkg::PROD_W-1:0] pvx4, pvz4;
  logic signed [PV_W-1:0] pvy4;
  logic signed [W-1:0] my5;
  logic signed [PV_W-1:0] pvx6, pvz6;
  logic signed [W-1:0] mx7, mz7;

  logic signed [DTS_W-1:0] dts3, dts5;
  logic drag3, drag4;
  logic signed [W-1:0] py8, vy8;

  always_comb begin
    en[8] = !v[8] || m_axis_tready;
    for (int i = 7; i >= 1; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign s_axis_tready = en[1];

  always_comb begin
    in_rec.kind = s_axis_tuser;
    in_rec.life = pis_pkg::sub_sat(s_axis_tdata[0*W +: W],
                                   W'({15'd0, s_axis_tdata[8*W +: pis_pkg::DT_W]}));
    in_rec.px   = s_axis_tdata[1*W +: W];
    in_rec.py   = s_axis_tdata[2*W +: W];
    in_rec.pz   = s_axis_tdata[3*W +: W];
    in_rec.vx   = s_axis_tdata[4*W +: W];
    in_rec.vy   = s_axis_tdata[5*W +: W];
    in_rec.vz   = s_axis_tdata[6*W +: W];
    in_rec.size = s_axis_tdata[7*W +: W];
    in_rec.dt   = s_axis_tdata[8*W +: pis_pkg::DT_W];
  end

  assign dts3 = $signed({1'b0, r3.dt});
  assign dts5 = $signed({1'b0, r5.dt});
  assign drag3 = (r3.kind == pis_pkg::KIND_SMOKE) || (r3.kind == pis_pkg::KIND_DUST);

  always_comb begin
    r3_next = r2;
    if (r2.kind == pis_pkg::KIND_SMOKE) begin
      r3_next.vy = pis_pkg::add_sat(r2.vy, mc2);
      r3_next.size = pis_pkg::add_sat(r2.size, md2);
    end else begin
      r3_next.vy = pis_pkg::sub_sat(r2.vy, mc2);
    end
  end

  always_comb begin
    r5_next = r4;
    if (drag4) begin
      r5_next.vx = pis_pkg::rnd_sat(pvx4);
      r5_next.vz = pis_pkg::rnd_sat(pvz4);
    end
  end

  always_comb begin
    r6_next = r5;
    r6_next.py = pis_pkg::add_sat(r5.py, my5);
  end

  always_comb begin
    r8_next = r7;
    r8_next.px = pis_pkg::add_sat(r7.px, mx7);
    r8_next.pz = pis_pkg::add_sat(r7.pz, mz7);
    if (r7.kind == pis_pkg::KIND_DUST && r7.py < $signed(pis_pkg::K_DUST_FLOOR)) begin
      r8_next.py = pis_pkg::K_DUST_FLOOR;
      r8_next.vy = '0;
    end
  end

  always_comb begin
    py8 = r8.py;
    vy8 = r8.vy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= s_axis_tvalid;
      for (int i = 2; i <= 7; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
      if (en[8]) v[8] <= v[7] && (r7.life > 0);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      r1 <= in_rec;
      pc1 <= $signed({32'd0, pis_pkg::rise_const(s_axis_tuser)} *
                     {47'd0, s_axis_tdata[8*W +: pis_pkg::DT_W]});
      pd1 <= $signed({32'd0, pis_pkg::drag_const(s_axis_tuser)} *
                     {47'd0, s_axis_tdata[8*W +: pis_pkg::DT_W]});
    end
    if (en[2]) begin
      r2 <= r1;
      mc2 <= pis_pkg::rnd_sat(pc1);
      md2 <= pis_pkg::rnd_sat(pd1);
    end
    if (en[3]) begin
      r3 <= r3_next;
      fac3 <= pis_pkg::sub_sat(pis_pkg::FX_ONE, md2);
    end
    if (en[4]) begin
      r4 <= r3;
      drag4 <= drag3;
      pvx4 <= PW'(r3.vx) * PW'(fac3);
      pvz4 <= PW'(r3.vz) * PW'(fac3);
      pvy4 <= PV_W'(r3.vy) * PV_W'(dts3);
    end
    if (en[5]) begin
      r5 <= r5_next;
      my5 <= pis_pkg::rnd_sat({{(pis_pkg::PROD_W - PV_W){pvy4[PV_W-1]}}, pvy4});
    end
    if (en[6]) begin
      r6 <= r6_next;
      pvx6 <= PV_W'(r5.vx) * PV_W'(dts5);
      pvz6 <= PV_W'(r5.vz) * PV_W'(dts5);
    end
    if (en[7]) begin
      r7 <= r6;
      mx7 <= pis_pkg::rnd_sat({{(pis_pkg::PROD_W - PV_W){pvx6[PV_W-1]}}, pvx6});
      mz7 <= pis_pkg::rnd_sat({{(pis_pkg::PROD_W - PV_W){pvz6[PV_W-1]}}, pvz6});
    end
    if (en[8]) begin
      r8 <= r8_next;
    end
  end

  assign m_axis_tvalid = v[8];
  assign m_axis_tuser = r8.kind;
  assign m_axis_tdata = {r8.size, r8.vz, vy8, r8.vx, r8.pz, py8, r8.px, r8.life};

endmodule
